FILE: design/hed_pkg.sv
// ----------------------------------------------------------------------------
// hed_pkg
// Shared types, character codes, the named reference table and the UTF-8
// helpers of the character reference decoder.
// ----------------------------------------------------------------------------
package hed_pkg;

	// character codes
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_LX    = 8'h78;
	localparam logic [7:0] CH_UX    = 8'h58;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_CR    = 8'h0D;

	// utf-8 range limits
	localparam logic [31:0] CP_LIM1 = 32'h80;
	localparam logic [31:0] CP_LIM2 = 32'h800;
	localparam logic [31:0] CP_LIM3 = 32'h10000;

	// named reference table
	localparam int NAME_MAX = 6;
	typedef logic [6:0] name_idx_t;
	localparam name_idx_t NAME_LAST = 7'd105;

	typedef struct packed {
		logic [8*NAME_MAX-1:0] chars;  // right aligned, first char highest
		logic [15:0]           cp;
	} name_ent_t;

	typedef enum logic [1:0] {
		EM_NONE = 2'd0,
		EM_TEXT = 2'd1,
		EM_AMP  = 2'd2,
		EM_CP   = 2'd3
	} emit_sel_t;

	typedef struct packed {
		logic      load;
		logic      shift;
		logic      set_ref;
		logic      clr_ref;
		logic      hold;
		logic      res_start;
		logic      parse_step;
		logic      name_step;
		logic      cp_name;
		logic      cp_num;
		logic      emit_next;
		logic      drop_step;
		logic      flush;
		emit_sel_t emit;
	} cmd_t;

	typedef struct packed {
		logic q_has;
		logic in_ref;
		logic amp;
		logic semi;
		logic blank;
		logic hc_full;
		logic last;
		logic num_ref;
		logic num_empty;
		logic parse_done;
		logic parse_hit;
		logic name_match;
		logic tbl_end;
		logic emit_last;
		logic drop_last;
		logic can_emit;
		logic pend_v;
		logic out_free;
	} sts_t;

	function automatic name_ent_t name_entry(input name_idx_t k);
		name_ent_t e;
		case (k)
			7'd0:   e = '{48'("amp"),    16'h0026};
			7'd1:   e = '{48'("lt"),     16'h003C};
			7'd2:   e = '{48'("gt"),     16'h003E};
			7'd3:   e = '{48'("quot"),   16'h0022};
			7'd4:   e = '{48'("apos"),   16'h0027};
			7'd5:   e = '{48'("nbsp"),   16'h00A0};
			7'd6:   e = '{48'("copy"),   16'h00A9};
			7'd7:   e = '{48'("reg"),    16'h00AE};
			7'd8:   e = '{48'("hellip"), 16'h2026};
			7'd9:   e = '{48'("mdash"),  16'h2014};
			7'd10:  e = '{48'("ndash"),  16'h2013};
			7'd11:  e = '{48'("lsquo"),  16'h2018};
			7'd12:  e = '{48'("rsquo"),  16'h2019};
			7'd13:  e = '{48'("ldquo"),  16'h201C};
			7'd14:  e = '{48'("rdquo"),  16'h201D};
			7'd15:  e = '{48'("trade"),  16'h2122};
			7'd16:  e = '{48'("middot"), 16'h00B7};
			7'd17:  e = '{48'("bull"),   16'h2022};
			7'd18:  e = '{48'("deg"),    16'h00B0};
			7'd19:  e = '{48'("plusmn"), 16'h00B1};
			7'd20:  e = '{48'("times"),  16'h00D7};
			7'd21:  e = '{48'("euro"),   16'h20AC};
			7'd22:  e = '{48'("pound"),  16'h00A3};
			7'd23:  e = '{48'("sect"),   16'h00A7};
			7'd24:  e = '{48'("laquo"),  16'h00AB};
			7'd25:  e = '{48'("raquo"),  16'h00BB};
			7'd26:  e = '{48'("para"),   16'h00B6};
			7'd27:  e = '{48'("shy"),    16'h00AD};
			7'd28:  e = '{48'("curren"), 16'h00A4};
			7'd29:  e = '{48'("yen"),    16'h00A5};
			7'd30:  e = '{48'("cent"),   16'h00A2};
			7'd31:  e = '{48'("frac12"), 16'h00BD};
			7'd32:  e = '{48'("frac14"), 16'h00BC};
			7'd33:  e = '{48'("sup2"),   16'h00B2};
			7'd34:  e = '{48'("sup3"),   16'h00B3};
			7'd35:  e = '{48'("micro"),  16'h00B5};
			7'd36:  e = '{48'("divide"), 16'h00F7};
			7'd37:  e = '{48'("iquest"), 16'h00BF};
			7'd38:  e = '{48'("iexcl"),  16'h00A1};
			7'd39:  e = '{48'("Agrave"), 16'h00C0};
			7'd40:  e = '{48'("Aacute"), 16'h00C1};
			7'd41:  e = '{48'("Acirc"),  16'h00C2};
			7'd42:  e = '{48'("Atilde"), 16'h00C3};
			7'd43:  e = '{48'("Auml"),   16'h00C4};
			7'd44:  e = '{48'("Aring"),  16'h00C5};
			7'd45:  e = '{48'("AElig"),  16'h00C6};
			7'd46:  e = '{48'("Ccedil"), 16'h00C7};
			7'd47:  e = '{48'("Egrave"), 16'h00C8};
			7'd48:  e = '{48'("Eacute"), 16'h00C9};
			7'd49:  e = '{48'("Ecirc"),  16'h00CA};
			7'd50:  e = '{48'("Euml"),   16'h00CB};
			7'd51:  e = '{48'("Igrave"), 16'h00CC};
			7'd52:  e = '{48'("Iacute"), 16'h00CD};
			7'd53:  e = '{48'("Icirc"),  16'h00CE};
			7'd54:  e = '{48'("Iuml"),   16'h00CF};
			7'd55:  e = '{48'("ETH"),    16'h00D0};
			7'd56:  e = '{48'("Ntilde"), 16'h00D1};
			7'd57:  e = '{48'("Ograve"), 16'h00D2};
			7'd58:  e = '{48'("Oacute"), 16'h00D3};
			7'd59:  e = '{48'("Ocirc"),  16'h00D4};
			7'd60:  e = '{48'("Otilde"), 16'h00D5};
			7'd61:  e = '{48'("Ouml"),   16'h00D6};
			7'd62:  e = '{48'("Oslash"), 16'h00D8};
			7'd63:  e = '{48'("Ugrave"), 16'h00D9};
			7'd64:  e = '{48'("Uacute"), 16'h00DA};
			7'd65:  e = '{48'("Ucirc"),  16'h00DB};
			7'd66:  e = '{48'("Uuml"),   16'h00DC};
			7'd67:  e = '{48'("Yacute"), 16'h00DD};
			7'd68:  e = '{48'("THORN"),  16'h00DE};
			7'd69:  e = '{48'("szlig"),  16'h00DF};
			7'd70:  e = '{48'("agrave"), 16'h00E0};
			7'd71:  e = '{48'("aacute"), 16'h00E1};
			7'd72:  e = '{48'("acirc"),  16'h00E2};
			7'd73:  e = '{48'("atilde"), 16'h00E3};
			7'd74:  e = '{48'("auml"),   16'h00E4};
			7'd75:  e = '{48'("aring"),  16'h00E5};
			7'd76:  e = '{48'("aelig"),  16'h00E6};
			7'd77:  e = '{48'("ccedil"), 16'h00E7};
			7'd78:  e = '{48'("egrave"), 16'h00E8};
			7'd79:  e = '{48'("eacute"), 16'h00E9};
			7'd80:  e = '{48'("ecirc"),  16'h00EA};
			7'd81:  e = '{48'("euml"),   16'h00EB};
			7'd82:  e = '{48'("igrave"), 16'h00EC};
			7'd83:  e = '{48'("iacute"), 16'h00ED};
			7'd84:  e = '{48'("icirc"),  16'h00EE};
			7'd85:  e = '{48'("iuml"),   16'h00EF};
			7'd86:  e = '{48'("eth"),    16'h00F0};
			7'd87:  e = '{48'("ntilde"), 16'h00F1};
			7'd88:  e = '{48'("ograve"), 16'h00F2};
			7'd89:  e = '{48'("oacute"), 16'h00F3};
			7'd90:  e = '{48'("ocirc"),  16'h00F4};
			7'd91:  e = '{48'("otilde"), 16'h00F5};
			7'd92:  e = '{48'("ouml"),   16'h00F6};
			7'd93:  e = '{48'("oslash"), 16'h00F8};
			7'd94:  e = '{48'("ugrave"), 16'h00F9};
			7'd95:  e = '{48'("uacute"), 16'h00FA};
			7'd96:  e = '{48'("ucirc"),  16'h00FB};
			7'd97:  e = '{48'("uuml"),   16'h00FC};
			7'd98:  e = '{48'("yacute"), 16'h00FD};
			7'd99:  e = '{48'("thorn"),  16'h00FE};
			7'd100: e = '{48'("yuml"),   16'h00FF};
			7'd101: e = '{48'("OElig"),  16'h0152};
			7'd102: e = '{48'("oelig"),  16'h0153};
			7'd103: e = '{48'("Scaron"), 16'h0160};
			7'd104: e = '{48'("scaron"), 16'h0161};
			7'd105: e = '{48'("Yuml"),   16'h0178};
			default: e = '0;
		endcase
		return e;
	endfunction

	// number of characters in a table name
	function automatic logic [2:0] name_len(input logic [8*NAME_MAX-1:0] chars);
		logic [2:0] n;
		n = '0;
		for (int j = 0; j < NAME_MAX; j++) begin
			if (chars[j*8 +: 8] != 8'h00) begin
				n = n + 3'd1;
			end
		end
		return n;
	endfunction

	// blanks that end a reference early
	function automatic logic is_blank(input logic [7:0] c);
		return (c == CH_SP) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR) || (c == CH_FF);
	endfunction

	// leading white space skipped before the digits
	function automatic logic is_lead_ws(input logic [7:0] c);
		return (c == CH_SP) || (c == CH_TAB) || (c == CH_LF) || (c == CH_VT) ||
			(c == CH_FF) || (c == CH_CR);
	endfunction

	// digit test: {ok, value}
	function automatic logic [4:0] digit_of(input logic [7:0] c, input logic hex);
		logic [4:0] r;
		r = '0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, c[3:0]};
		end else if (hex && c >= 8'h61 && c <= 8'h66) begin
			r = {1'b1, c[3:0] + 4'd9};
		end else if (hex && c >= 8'h41 && c <= 8'h46) begin
			r = {1'b1, c[3:0] + 4'd9};
		end
		return r;
	endfunction

	// index of the last utf-8 byte of a code point
	function automatic logic [1:0] utf8_last(input logic [31:0] cp);
		logic [1:0] r;
		if (cp < CP_LIM1) begin
			r = 2'd0;
		end else if (cp < CP_LIM2) begin
			r = 2'd1;
		end else if (cp < CP_LIM3) begin
			r = 2'd2;
		end else begin
			r = 2'd3;
		end
		return r;
	endfunction

	// utf-8 byte number e of a code point
	function automatic logic [7:0] utf8_byte(input logic [31:0] cp, input logic [1:0] e);
		logic [7:0] b;
		case (utf8_last(cp))
			2'd0: b = cp[7:0];
			2'd1: b = (e == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
			2'd2: begin
				case (e)
					2'd0:    b = {4'hE, cp[15:12]};
					2'd1:    b = {2'b10, cp[11:6]};
					default: b = {2'b10, cp[5:0]};
				endcase
			end
			default: begin
				case (e)
					2'd0:    b = 8'hF0 | cp[25:18];
					2'd1:    b = {2'b10, cp[17:12]};
					2'd2:    b = {2'b10, cp[11:6]};
					default: b = {2'b10, cp[5:0]};
				endcase
			end
		endcase
		return b;
	endfunction

endpackage

FILE: design/hed_text_if.sv
// ----------------------------------------------------------------------------
// hed_text_if
// Valid/ready channel carrying raw text bytes into the decoder.
// ----------------------------------------------------------------------------
interface hed_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       text_last;

	modport source(output valid, text_byte, text_last, input ready);
	modport sink(input valid, text_byte, text_last, output ready);
endinterface

FILE: design/hed_dec_if.sv
// ----------------------------------------------------------------------------
// hed_dec_if
// Valid/ready channel carrying decoded bytes out of the decoder.
// ----------------------------------------------------------------------------
interface hed_dec_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       run_last;
	logic       text_end;

	modport source(output valid, out_byte, run_last, text_end, input ready);
	modport sink(input valid, out_byte, run_last, text_end, output ready);
endinterface

FILE: design/html_entity_decoder.sv
// ----------------------------------------------------------------------------
// html_entity_decoder
// Streaming decoder of HTML character references, text bytes in, decoded
// bytes out.
// ----------------------------------------------------------------------------
// One text item is taken at a time. A plain byte passes through accept, scan
// and end of item. A byte that completes a reference adds a resolve step,
// then either the number reader stepping over the held bytes for a numeric
// reference or a linear walk of the name table (106 entries) for a name,
// then the utf-8 bytes one by one and the drop of the window bytes, the ';'
// included. A miss emits the '&' and then rescans the window bytes. The last
// decoded byte of an item is kept back one slot so it can carry run_last; a
// full output register stalls the sequencer.
// WINDOW sets how far after the '&' the closing ';' may stand.
// ----------------------------------------------------------------------------
module html_entity_decoder #(
	parameter int WINDOW = 12
) (
	input  logic       clk,
	input  logic       arst_n,
	hed_text_if.sink   text,
	hed_dec_if.source  decoded
);
	import hed_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequencer
	hed_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (text.valid),
		.in_ready (text.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// window and decode datapath
	hed_datapath #(
		.WINDOW (WINDOW)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.in_byte      (text.text_byte),
		.in_last      (text.text_last),
		.out_valid    (decoded.valid),
		.out_ready    (decoded.ready),
		.out_byte     (decoded.out_byte),
		.out_run_last (decoded.run_last),
		.out_text_end (decoded.text_end)
	);

endmodule

FILE: design/hed_datapath.sv
// ----------------------------------------------------------------------------
// hed_datapath
// Byte window, reference counters, number reader, name table walk, utf-8
// encoder and the output stage of the decoder.
// ----------------------------------------------------------------------------
module hed_datapath #(
	parameter int WINDOW = 12
) (
	input  logic          clk,
	input  logic          arst_n,
	input  hed_pkg::cmd_t cmd,
	output hed_pkg::sts_t sts,
	input  logic [7:0]    in_byte,
	input  logic          in_last,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [7:0]    out_byte,
	output logic          out_run_last,
	output logic          out_text_end
);
	import hed_pkg::*;

	localparam int IW = $clog2(WINDOW);
	localparam int NW = $clog2(WINDOW + 1);

	typedef enum logic [3:0] {
		PH_WS  = 4'b0001,
		PH_PFX = 4'b0010,
		PH_X   = 4'b0100,
		PH_DIG = 4'b1000
	} phase_t;

	logic [7:0]    win_q [WINDOW];
	logic [7:0]    win_pad [NAME_MAX];
	logic [NW-1:0] n_q;
	logic [IW-1:0] hc_q;
	logic          ref_q;
	logic          last_q;
	logic [IW-1:0] p_q;
	logic [31:0]   acc_q;
	logic          neg_q;
	logic          hex_q;
	phase_t        ph_q;
	name_idx_t     k_q;
	logic [31:0]   cp_q;
	logic [1:0]    e_q;
	logic          pend_v_q;
	logic [7:0]    pend_b_q;
	logic          out_v_q;
	logic [7:0]    out_b_q;
	logic          out_rl_q;
	logic          out_te_q;

	logic [IW-1:0] rd_idx;
	logic [7:0]    cur;
	logic [4:0]    dg;
	logic          hex_now;
	logic          pdone;
	logic          win_shift;
	name_ent_t     ent;
	logic          nmatch;
	logic [7:0]    emit_b;
	logic          out_free;
	logic          load_out;
	logic [31:0]   acc_nx;

	// fixed taps for the name compare and the resolve checks
	for (genvar j = 0; j < NAME_MAX; j++) begin : g_pad
		if (j < WINDOW) begin : g_tap
			assign win_pad[j] = win_q[j];
		end else begin : g_zero
			assign win_pad[j] = '0;
		end
	end

	// single read port of the window
	assign rd_idx  = cmd.parse_step ? p_q : hc_q;
	assign cur     = win_q[rd_idx];
	assign dg      = digit_of(cur, hex_q);
	assign hex_now = (win_pad[1] == CH_LX) || (win_pad[1] == CH_UX);
	assign pdone   = (p_q >= hc_q) || ((ph_q == PH_DIG) && !dg[4]);
	assign acc_nx  = hex_q ? {acc_q[27:0], dg[3:0]}
		: (acc_q << 3) + (acc_q << 1) + {28'd0, dg[3:0]};

	// name table compare against the held bytes
	assign ent = name_entry(k_q);
	always_comb begin
		logic [2:0] ln;
		int         idx;
		ln     = name_len(ent.chars);
		nmatch = (8'(ln) == 8'(hc_q));
		for (int j = 0; j < NAME_MAX; j++) begin
			idx = int'(ln) - 1 - j;
			if (j < int'(ln) && win_pad[j] != ent.chars[idx*8 +: 8]) begin
				nmatch = 1'b0;
			end
		end
	end

	// byte to emit
	always_comb begin
		case (cmd.emit)
			EM_TEXT: emit_b = cur;
			EM_AMP:  emit_b = CH_AMP;
			EM_CP:   emit_b = utf8_byte(cp_q, e_q);
			default: emit_b = cur;
		endcase
	end

	assign win_shift = cmd.shift || cmd.drop_step;
	assign out_free  = !out_v_q || out_ready;
	assign load_out  = ((cmd.emit != EM_NONE) && pend_v_q) || cmd.flush;

	// status to the controller
	always_comb begin
		sts            = '0;
		sts.q_has      = NW'(hc_q) < n_q;
		sts.in_ref     = ref_q;
		sts.amp        = cur == CH_AMP;
		sts.semi       = cur == CH_SEMI;
		sts.blank      = is_blank(cur);
		sts.hc_full    = hc_q == IW'(WINDOW - 1);
		sts.last       = last_q;
		sts.num_ref    = (hc_q > IW'(1)) && (win_pad[0] == CH_HASH);
		sts.num_empty  = hex_now && (hc_q == IW'(2));
		sts.parse_done = pdone;
		sts.parse_hit  = acc_q != '0;
		sts.name_match = nmatch;
		sts.tbl_end    = k_q == NAME_LAST;
		sts.emit_last  = e_q == utf8_last(cp_q);
		sts.drop_last  = hc_q == '0;
		sts.can_emit   = !pend_v_q || out_free;
		sts.pend_v     = pend_v_q;
		sts.out_free   = out_free;
	end

	// window storage
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			win_q[n_q[IW-1:0]] <= in_byte;
		end else if (win_shift) begin
			for (int j = 0; j < WINDOW - 1; j++) begin
				win_q[j] <= win_q[j+1];
			end
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q      <= '0;
			hc_q     <= '0;
			ref_q    <= 1'b0;
			last_q   <= 1'b0;
			p_q      <= '0;
			ph_q     <= PH_WS;
			k_q      <= '0;
			e_q      <= '0;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			// window fill level
			if (cmd.load) begin
				n_q    <= n_q + NW'(1);
				last_q <= in_last;
			end else if (win_shift) begin
				n_q <= n_q - NW'(1);
			end

			// held count and reference flag
			if (cmd.set_ref) begin
				hc_q  <= '0;
				ref_q <= 1'b1;
			end else if (cmd.clr_ref) begin
				hc_q  <= '0;
				ref_q <= 1'b0;
			end else if (cmd.hold) begin
				hc_q <= hc_q + IW'(1);
			end else if (cmd.drop_step) begin
				if (hc_q != '0) begin
					hc_q <= hc_q - IW'(1);
				end else begin
					ref_q <= 1'b0;
				end
			end

			// number reader and name table sequencing
			if (cmd.res_start) begin
				p_q  <= hex_now ? IW'(2) : IW'(1);
				ph_q <= PH_WS;
				k_q  <= '0;
			end else if (cmd.parse_step && !pdone) begin
				case (ph_q)
					PH_WS: begin
						if (is_lead_ws(cur)) begin
							p_q <= p_q + IW'(1);
						end else if (cur == CH_PLUS || cur == CH_MINUS) begin
							p_q  <= p_q + IW'(1);
							ph_q <= PH_PFX;
						end else begin
							ph_q <= PH_PFX;
						end
					end
					PH_PFX: begin
						if (hex_q && cur == CH_ZERO) begin
							p_q  <= p_q + IW'(1);
							ph_q <= PH_X;
						end else begin
							ph_q <= PH_DIG;
						end
					end
					PH_X: begin
						if (cur == CH_LX || cur == CH_UX) begin
							p_q <= p_q + IW'(1);
						end
						ph_q <= PH_DIG;
					end
					PH_DIG: begin
						p_q <= p_q + IW'(1);
					end
					default: ph_q <= PH_WS;
				endcase
			end else if (cmd.name_step) begin
				k_q <= k_q + 7'd1;
			end

			// utf-8 byte counter
			if (cmd.cp_name || cmd.cp_num) begin
				e_q <= '0;
			end else if (cmd.emit_next) begin
				e_q <= e_q + 2'd1;
			end

			// pending byte and output register
			if (cmd.emit != EM_NONE) begin
				pend_v_q <= 1'b1;
			end else if (cmd.flush) begin
				pend_v_q <= 1'b0;
			end
			if (load_out) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.res_start) begin
			acc_q <= '0;
			neg_q <= 1'b0;
			hex_q <= hex_now;
		end else if (cmd.parse_step && !pdone) begin
			if (ph_q == PH_WS && (cur == CH_PLUS || cur == CH_MINUS) && !is_lead_ws(cur)) begin
				neg_q <= cur == CH_MINUS;
			end
			if (ph_q == PH_DIG) begin
				acc_q <= acc_nx;
			end
		end
		if (cmd.cp_name) begin
			cp_q <= {16'd0, ent.cp};
		end else if (cmd.cp_num) begin
			cp_q <= neg_q ? (32'd0 - acc_q) : acc_q;
		end
		if (cmd.emit != EM_NONE) begin
			pend_b_q <= emit_b;
		end
		if (load_out) begin
			out_b_q  <= pend_b_q;
			out_rl_q <= cmd.flush;
			out_te_q <= cmd.flush && last_q;
		end
	end

	assign out_valid    = out_v_q;
	assign out_byte     = out_b_q;
	assign out_run_last = out_rl_q;
	assign out_text_end = out_te_q;

endmodule

FILE: design/hed_ctrl.sv
// ----------------------------------------------------------------------------
// hed_ctrl
// Controller of the decoder: sequences scan, resolve, number read, name
// walk, utf-8 emit, window drop and the miss path.
// ----------------------------------------------------------------------------
module hed_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  hed_pkg::sts_t sts,
	output hed_pkg::cmd_t cmd
);
	import hed_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE    = 8'b00000001,
		S_SCAN    = 8'b00000010,
		S_MISS    = 8'b00000100,
		S_RESOLVE = 8'b00001000,
		S_PARSE   = 8'b00010000,
		S_NAME    = 8'b00100000,
		S_EMIT    = 8'b01000000,
		S_DROP    = 8'b10000000
	} state_t;

	state_t state_q;
	state_t state_nx;

	assign in_ready = state_q == S_IDLE;

	// next state and commands
	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		cmd.emit = EM_NONE;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_nx = S_SCAN;
				end
			end
			S_SCAN: begin
				if (sts.q_has) begin
					if (!sts.in_ref) begin
						if (sts.amp) begin
							cmd.shift   = 1'b1;
							cmd.set_ref = 1'b1;
						end else if (sts.can_emit) begin
							cmd.emit  = EM_TEXT;
							cmd.shift = 1'b1;
						end
					end else if (sts.semi) begin
						state_nx = S_RESOLVE;
					end else if (!sts.blank && !sts.hc_full) begin
						cmd.hold = 1'b1;
					end else begin
						state_nx = S_MISS;
					end
				end else if (sts.last && sts.in_ref) begin
					state_nx = S_MISS;
				end else if (!sts.pend_v) begin
					state_nx = S_IDLE;
				end else if (sts.out_free) begin
					cmd.flush = 1'b1;
					state_nx  = S_IDLE;
				end
			end
			S_MISS: begin
				if (sts.can_emit) begin
					cmd.emit    = EM_AMP;
					cmd.clr_ref = 1'b1;
					state_nx    = S_SCAN;
				end
			end
			S_RESOLVE: begin
				cmd.res_start = 1'b1;
				if (!sts.num_ref) begin
					state_nx = S_NAME;
				end else if (sts.num_empty) begin
					state_nx = S_MISS;
				end else begin
					state_nx = S_PARSE;
				end
			end
			S_PARSE: begin
				cmd.parse_step = 1'b1;
				if (sts.parse_done) begin
					if (sts.parse_hit) begin
						cmd.cp_num = 1'b1;
						state_nx   = S_EMIT;
					end else begin
						state_nx = S_MISS;
					end
				end
			end
			S_NAME: begin
				if (sts.name_match) begin
					cmd.cp_name = 1'b1;
					state_nx    = S_EMIT;
				end else if (sts.tbl_end) begin
					state_nx = S_MISS;
				end else begin
					cmd.name_step = 1'b1;
				end
			end
			S_EMIT: begin
				if (sts.can_emit) begin
					cmd.emit      = EM_CP;
					cmd.emit_next = 1'b1;
					if (sts.emit_last) begin
						state_nx = S_DROP;
					end
				end
			end
			S_DROP: begin
				cmd.drop_step = 1'b1;
				if (sts.drop_last) begin
					state_nx = S_SCAN;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

endmodule
